// File: hw/rtl/fqr_pkg.sv
`timescale 1ns / 1ps

package fqr_pkg;

  // Field widths of the command and response items.
  localparam int VAL_W = 32;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;
  localparam int OCC_W = 5;

  // Operation codes; the fourth code is a no-op.
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Command item: what to do and the value or key it applies to.
  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] value;
  } cmd_item_t;

  // Response item: outcome and occupancy after the command.
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [OCC_W-1:0] occupancy;
  } rsp_item_t;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_APPLY
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic apply;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic result_busy;
  } dp_status_t;

endpackage

// File: hw/rtl/fqr_ctrl.sv
`timescale 1ns / 1ps

module fqr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  fqr_pkg::dp_status_t    sts,
  output fqr_pkg::ctrl_cmd_t     ctl
);

  fqr_pkg::ctrl_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fqr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands. An item is taken in idle, where each
  // cell compares its entry with the key; the update follows once the
  // response register is free.
  always_comb begin
    state_next  = state;
    cmd_stall   = 1'b1;
    ctl.capture = 1'b0;
    ctl.apply   = 1'b0;
    case (state)
      fqr_pkg::S_IDLE: begin
        cmd_stall   = 1'b0;
        ctl.capture = cmd_valid;
        if (cmd_valid) begin
          state_next = fqr_pkg::S_APPLY;
        end
      end
      fqr_pkg::S_APPLY: begin
        if (!sts.result_busy) begin
          ctl.apply  = 1'b1;
          state_next = fqr_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fqr_pkg::S_IDLE;
      end
    endcase
  end

  // A captured item is always followed by its apply step, never by another capture.
  a_capture_then_apply: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |=> (state == fqr_pkg::S_APPLY) && !ctl.capture)
    else $error("capture not followed by apply state");

  // Apply only happens while the response register can be loaded.
  a_apply_when_free: assert property (@(posedge clk) disable iff (rst)
    ctl.apply |-> !sts.result_busy)
    else $error("apply while response held");

  // Items are only taken in idle.
  a_take_in_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |-> (state == fqr_pkg::S_IDLE))
    else $error("item taken outside idle");

endmodule

// File: hw/rtl/fqr_datapath.sv
`timescale 1ns / 1ps

module fqr_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fqr_pkg::cmd_item_t    cmd,
  input  fqr_pkg::ctrl_cmd_t    ctl,
  output fqr_pkg::dp_status_t   sts,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output fqr_pkg::rsp_item_t    rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  logic signed [fqr_pkg::VAL_W-1:0] entries [DEPTH];
  logic [CW-1:0]                    count;
  logic [CW-1:0]                    count_next;
  logic [DEPTH-1:0]                 hit;
  logic [DEPTH-1:0]                 match;
  logic [DEPTH-1:0]                 shift_en;
  logic [fqr_pkg::OP_W-1:0]         op;
  logic signed [fqr_pkg::VAL_W-1:0] key;
  logic                             found;
  logic                             full;
  logic                             empty;
  logic                             do_append;
  logic                             do_remove;
  fqr_pkg::status_t                 status_next;

  // Per-cell compare against the incoming key, and the shift enable for a
  // removal: every cell at or above the oldest match takes its neighbour.
  for (genvar j = 0; j < DEPTH; j++) begin : g_cmp
    assign hit[j]      = (entries[j] == cmd.value) && (CW'(j) < count);
    assign shift_en[j] = |match[j:0];
  end

  // Capture the operation, the key and the match vector when an item is taken.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op    <= cmd.operation;
      key   <= cmd.value;
      match <= hit;
    end
  end

  // Decide the outcome of the captured operation.
  always_comb begin
    found       = |match;
    full        = (count == CW'(DEPTH));
    empty       = (count == '0);
    do_append   = 1'b0;
    do_remove   = 1'b0;
    count_next  = count;
    status_next = fqr_pkg::ST_DONE;
    case (op)
      fqr_pkg::OP_APPEND: begin
        if (full) begin
          status_next = fqr_pkg::ST_FULL;
        end else begin
          do_append  = 1'b1;
          count_next = count + CW'(1);
        end
      end
      fqr_pkg::OP_REMOVE: begin
        if (empty) begin
          status_next = fqr_pkg::ST_EMPTY;
        end else if (!found) begin
          status_next = fqr_pkg::ST_NOT_FOUND;
        end else begin
          do_remove  = 1'b1;
          count_next = count - CW'(1);
        end
      end
      fqr_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        status_next = fqr_pkg::ST_DONE;
      end
    endcase
  end

  // Storage cells: append writes the tail cell, removal closes the gap.
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    if (j < DEPTH - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (ctl.apply) begin
          if (do_append && (CW'(j) == count)) begin
            entries[j] <= key;
          end else if (do_remove && shift_en[j]) begin
            entries[j] <= entries[j+1];
          end
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (ctl.apply && do_append && (CW'(j) == count)) begin
          entries[j] <= key;
        end
      end
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.apply) begin
      count <= count_next;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.apply) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      rsp.status    <= status_next;
      rsp.occupancy <= fqr_pkg::OCC_W'(count_next);
    end
  end

  assign sts.result_busy = rsp_valid && rsp_stall;

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above capacity");

  // Every apply step presents a response on the next cycle.
  a_apply_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    ctl.apply |=> rsp_valid)
    else $error("apply without response");

  // A clear leaves the queue empty.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    ctl.apply && (op == fqr_pkg::OP_CLEAR) |=> (count == '0))
    else $error("clear left entries");

  // Count moves only on an apply step.
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !ctl.apply |=> $stable(count))
    else $error("count changed without apply");

endmodule

// File: hw/rtl/fifo_queue_with_remove_by_value.sv
`timescale 1ns / 1ps

// Bounded FIFO of signed 32-bit values with append, remove-oldest-equal and
// clear commands; every command item returns one response item with a status
// and the occupancy after the command. In the cycle an item is taken, every
// storage cell compares its entry with the key in parallel and the match
// vector is registered; the controller then applies the update (tail write,
// gap-closing shift or clear) and loads the response register. A response
// left waiting under stall holds the next item in its apply step until it is
// taken. Reset clears the count at once; there is no clearing pass, and
// storage contents are undefined until written. The occupancy field carries
// the low five bits of the count.
module fifo_queue_with_remove_by_value #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  fqr_pkg::cmd_item_t  cmd,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output fqr_pkg::rsp_item_t  rsp
);

  fqr_pkg::ctrl_cmd_t  ctl;
  fqr_pkg::dp_status_t sts;

  // Sequencer.
  fqr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Storage cells, count and response register.
  fqr_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH = 16;
  localparam int RANDOM_ITEMS = 1000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT = 3000;
  localparam int MAX_REPORTS = 10;
  // The fourth operation code has no name in the package; the block ignores it.
  localparam logic [fqr_pkg::OP_W-1:0] OP_NOP = 2'd3;

  logic               clk;
  logic               rst;
  logic               cmd_valid;
  logic               cmd_stall;
  fqr_pkg::cmd_item_t cmd;
  logic               rsp_valid;
  logic               rsp_stall;
  fqr_pkg::rsp_item_t rsp;

  fifo_queue_with_remove_by_value #(
    .DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // One row of the directed table; want is used only where typed is set.
  typedef struct {
    fqr_pkg::cmd_item_t item;
    bit                 typed;
    fqr_pkg::rsp_item_t want;
  } dir_row_t;

  dir_row_t                  directed_rows[$];
  fqr_pkg::rsp_item_t        pending_rsps[$];
  logic [fqr_pkg::VAL_W-1:0] fifo_entries[DEPTH];
  int unsigned               fifo_count;
  int                        mismatches = 0;
  int                        idle_cycles = 0;
  bit                        tx_idle_en;
  bit                        rx_idle_en;
  bit                        hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predicts the response to one command and updates the queue contents.
  function automatic fqr_pkg::rsp_item_t fifo_predict(fqr_pkg::cmd_item_t c);
    fqr_pkg::rsp_item_t r;
    int                 hit;
    int                 i;
    r.status = fqr_pkg::ST_DONE;
    case (c.operation)
      fqr_pkg::OP_APPEND: begin
        if (fifo_count >= DEPTH) begin
          r.status = fqr_pkg::ST_FULL;
        end else begin
          fifo_entries[fifo_count] = c.value;
          fifo_count++;
        end
      end
      fqr_pkg::OP_REMOVE: begin
        hit = -1;
        for (i = 0; i < fifo_count; i++) begin
          if (hit < 0 && fifo_entries[i] == c.value) hit = i;
        end
        if (fifo_count == 0) begin
          r.status = fqr_pkg::ST_EMPTY;
        end else if (hit < 0) begin
          r.status = fqr_pkg::ST_NOT_FOUND;
        end else begin
          // Close the gap so that the remaining entries keep their order.
          for (i = hit; i + 1 < fifo_count; i++) fifo_entries[i] = fifo_entries[i + 1];
          fifo_count--;
        end
      end
      fqr_pkg::OP_CLEAR: begin
        fifo_count = 0;
      end
      default: begin
      end
    endcase
    r.occupancy = fqr_pkg::OCC_W'(fifo_count);
    return r;
  endfunction

  task automatic add_row(logic [fqr_pkg::OP_W-1:0] op, logic [fqr_pkg::VAL_W-1:0] v,
                         bit typed, fqr_pkg::status_t st, int occ);
    dir_row_t row;
    row.item.operation = op;
    row.item.value     = v;
    row.typed          = typed;
    row.want.status    = st;
    row.want.occupancy = fqr_pkg::OCC_W'(occ);
    directed_rows.push_back(row);
  endtask

  // Offers one item after a random gap and records its expected response once taken.
  task automatic send_item(fqr_pkg::cmd_item_t c, bit typed, fqr_pkg::rsp_item_t want);
    int                 gap;
    fqr_pkg::rsp_item_t predicted;
    gap = tx_idle_en ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predicted = fifo_predict(c);
    pending_rsps.push_back(typed ? want : predicted);
  endtask

  // Sender: reset, the directed table, then random commands.
  initial begin
    fqr_pkg::cmd_item_t c;
    int                 n;
    int                 r;
    int                 append_pct;
    rst        = 1'b1;
    cmd_valid  = 1'b0;
    cmd        = '0;
    fifo_count = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_req   = 1'b0;
    append_pct = 50;

    // Empty queue cases, then the value extremes, a miss and a hit.
    add_row(fqr_pkg::OP_REMOVE, 32'h0000_0000, 1'b1, fqr_pkg::ST_EMPTY, 0);
    add_row(fqr_pkg::OP_CLEAR, 32'h0000_0000, 1'b1, fqr_pkg::ST_DONE, 0);
    add_row(OP_NOP, 32'hFFFF_FFFF, 1'b1, fqr_pkg::ST_DONE, 0);
    add_row(fqr_pkg::OP_APPEND, 32'h8000_0000, 1'b1, fqr_pkg::ST_DONE, 1);
    add_row(fqr_pkg::OP_APPEND, 32'h7FFF_FFFF, 1'b1, fqr_pkg::ST_DONE, 2);
    add_row(fqr_pkg::OP_APPEND, 32'h0000_0000, 1'b1, fqr_pkg::ST_DONE, 3);
    add_row(fqr_pkg::OP_APPEND, 32'hFFFF_FFFF, 1'b1, fqr_pkg::ST_DONE, 4);
    add_row(fqr_pkg::OP_REMOVE, 32'h0000_0005, 1'b1, fqr_pkg::ST_NOT_FOUND, 4);
    add_row(fqr_pkg::OP_REMOVE, 32'h7FFF_FFFF, 1'b1, fqr_pkg::ST_DONE, 3);
    // Fill to the brim, then append when full, ignore the spare code and clear.
    for (n = 0; n < DEPTH - 3; n++) begin
      add_row(fqr_pkg::OP_APPEND, 32'h1000 + n, 1'b0, fqr_pkg::ST_DONE, 0);
    end
    add_row(fqr_pkg::OP_APPEND, 32'h1234_5678, 1'b1, fqr_pkg::ST_FULL, DEPTH);
    add_row(OP_NOP, 32'h0000_0000, 1'b1, fqr_pkg::ST_DONE, DEPTH);
    add_row(fqr_pkg::OP_CLEAR, 32'h0000_0000, 1'b1, fqr_pkg::ST_DONE, 0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // Change the idling and the append bias every hundred items.
      if (n % 100 == 0) begin
        tx_idle_en = (n != 0) && ($urandom_range(0, 3) != 0);
        rx_idle_en = (n != 0) && ($urandom_range(0, 3) != 0);
        append_pct = $urandom_range(30, 80);
      end
      if (n == 300) hold_req = 1'b1;
      // Let the block drain completely before carrying on.
      if (n == 600) begin
        cmd_valid <= 1'b0;
        do @(posedge clk); while (pending_rsps.size() != 0);
      end

      r = $urandom_range(0, 99);
      if (r < 3) c.operation = fqr_pkg::OP_CLEAR;
      else if (r < 6) c.operation = OP_NOP;
      else if ($urandom_range(0, 99) < append_pct) c.operation = fqr_pkg::OP_APPEND;
      else c.operation = fqr_pkg::OP_REMOVE;

      // Removes mostly name a value that is held, so that hits are common.
      if (c.operation == fqr_pkg::OP_REMOVE && fifo_count > 0 &&
          $urandom_range(0, 99) < 65) begin
        c.value = fifo_entries[$urandom_range(0, fifo_count - 1)];
      end else begin
        case ($urandom_range(0, 7))
          0: c.value = 32'h8000_0000;
          1: c.value = 32'h7FFF_FFFF;
          2: c.value = 32'h0000_0000;
          3: c.value = 32'hFFFF_FFFF;
          4, 5: c.value = $urandom_range(1, 4);
          default: c.value = $urandom();
        endcase
      end
      send_item(c, 1'b0, '0);
    end
    cmd_valid <= 1'b0;

    do @(posedge clk); while (pending_rsps.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_rsps.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: while idling is enabled, stalls for a random number of cycles before taking each item.
  initial begin
    int n;
    bit held;
    held      = 1'b0;
    rsp_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      // A long hold-off so that the block fills up and stalls its input.
      if (hold_req && !held) begin
        held = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      n = rx_idle_en ? $urandom_range(0, 15) : 0;
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  // Compare each response taken with the oldest expectation.
  always @(posedge clk) begin
    fqr_pkg::rsp_item_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected response: status %0d occupancy %0d",
                   rsp.status, rsp.occupancy);
        end
      end else begin
        want = pending_rsps.pop_front();
        if (rsp.status !== want.status || rsp.occupancy !== want.occupancy) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("response mismatch: expected status %0d occupancy %0d,",
                     want.status, want.occupancy,
                     " got status %0d occupancy %0d", rsp.status, rsp.occupancy);
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule
